// ===== rtl/core/binding_table_engine_assert.svh =====
// Assertion macros shared by the binding table engine.
// Each check is sampled on i_clk and masked while i_rst_n is low.
`ifndef BINDING_TABLE_ENGINE_ASSERT_SVH
`define BINDING_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication
`define BTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bte_pkg.sv =====
`default_nettype none

package bte_pkg;

    // Table depth and the index / count widths that go with it
    localparam int CAPACITY   = 16;
    localparam int SLOT_BITS  = 4;
    localparam int COUNT_BITS = 5;

    // Port field widths
    localparam int KEY_W   = 16;
    localparam int PLACE_W = 8;

    typedef enum logic [1:0] {
        OP_UPSERT     = 2'd0,
        OP_FIND_ID    = 2'd1,
        OP_FIND_PLACE = 2'd2,
        OP_ERASE      = 2'd3
    } t_op;

    // Controller to datapath commands
    typedef struct packed {
        logic load;  // capture the incoming request
        logic exec;  // evaluate, update table, register result
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/bte_ctrl.sv =====
`default_nettype none

module bte_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output bte_pkg::t_cmd      o_cmd
);
    import bte_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   w_cmd;

    // Commands: execute only once the output register is free or draining
    always_comb begin
        w_cmd.load = (r_state == S_IDLE) && i_in_valid;
        w_cmd.exec = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_cmd.load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_cmd.exec) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

// ===== rtl/core/bte_dpath.sv =====
`default_nettype none

module bte_dpath #(
    parameter int ID_BITS    = 16,
    parameter int PLACE_BITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bte_pkg::t_cmd                     i_cmd,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [bte_pkg::KEY_W-1:0]         i_key_id,
    input  wire logic [bte_pkg::PLACE_W-1:0]       i_place_index,
    input  wire logic [bte_pkg::SLOT_BITS-1:0]     i_slot_index,
    output logic                                   o_hit,
    output logic [bte_pkg::SLOT_BITS-1:0]          o_hit_slot,
    output logic [bte_pkg::KEY_W-1:0]              o_hit_id,
    output logic [bte_pkg::PLACE_W-1:0]            o_hit_place,
    output logic [bte_pkg::COUNT_BITS-1:0]         o_occupancy,
    output logic                                   o_overflow
);
    import bte_pkg::*;

    localparam int ID_EXT_W = (ID_BITS > KEY_W) ? ID_BITS : KEY_W;
    localparam int PL_EXT_W = (PLACE_BITS > PLACE_W) ? PLACE_BITS : PLACE_W;

    // Request registers
    t_op                   r_op;
    logic [ID_BITS-1:0]    r_id;
    logic [PLACE_BITS-1:0] r_place;
    logic [SLOT_BITS-1:0]  r_slot;

    // Table storage and fill count
    logic [ID_BITS-1:0]    r_ids    [CAPACITY];
    logic [PLACE_BITS-1:0] r_places [CAPACITY];
    logic [COUNT_BITS-1:0] r_count, n_count;

    // Result registers
    logic                  r_hit, n_hit;
    logic [SLOT_BITS-1:0]  r_hslot, n_hslot;
    logic [ID_BITS-1:0]    r_hid, n_hid;
    logic [PLACE_BITS-1:0] r_hplace, n_hplace;
    logic                  r_ovf, n_ovf;

    logic [ID_EXT_W-1:0]   w_key_ext, w_hid_ext;
    logic [PL_EXT_W-1:0]   w_place_ext, w_hplace_ext;

    logic [CAPACITY-1:0]   w_live, w_match_id, w_match_pl;
    logic                  w_found_id, w_found_pl;
    logic [SLOT_BITS-1:0]  w_sel_id, w_sel_pl, w_sel, w_last;
    logic                  w_erase_ok;

    logic                  w_wr_en, w_wr_id_en;
    logic [SLOT_BITS-1:0]  w_wr_idx;
    logic [ID_BITS-1:0]    w_wr_id;
    logic [PLACE_BITS-1:0] w_wr_place;

    // Fit port fields to the stored widths
    assign w_key_ext   = ID_EXT_W'(i_key_id);
    assign w_place_ext = PL_EXT_W'(i_place_index);

    // Capture request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_opcode);
            r_id    <= w_key_ext[ID_BITS-1:0];
            r_place <= w_place_ext[PLACE_BITS-1:0];
            r_slot  <= i_slot_index;
        end
    end

    // Parallel compare against every live entry
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_live[i]     = COUNT_BITS'(i) < r_count;
            w_match_id[i] = w_live[i] && (r_ids[i] == r_id);
            w_match_pl[i] = w_live[i] && (r_places[i] == r_place)
                            && ((r_id == '0) || (r_ids[i] == r_id));
        end
    end

    // Lowest matching slot
    always_comb begin
        w_sel_id   = '0;
        w_found_id = 1'b0;
        w_sel_pl   = '0;
        w_found_pl = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_match_id[i]) begin
                w_sel_id   = SLOT_BITS'(i);
                w_found_id = 1'b1;
            end
            if (w_match_pl[i]) begin
                w_sel_pl   = SLOT_BITS'(i);
                w_found_pl = 1'b1;
            end
        end
    end

    assign w_sel      = (r_op == OP_FIND_PLACE) ? w_sel_pl : w_sel_id;
    assign w_last     = SLOT_BITS'(r_count - COUNT_BITS'(1));
    assign w_erase_ok = COUNT_BITS'(r_slot) < r_count;

    // Result and table update for the current opcode
    always_comb begin
        n_hit      = 1'b0;
        n_hslot    = '0;
        n_hid      = '0;
        n_hplace   = '0;
        n_ovf      = 1'b0;
        n_count    = r_count;
        w_wr_en    = 1'b0;
        w_wr_id_en = 1'b0;
        w_wr_idx   = '0;
        w_wr_id    = r_id;
        w_wr_place = r_place;
        case (r_op)
            OP_UPSERT: begin
                if (w_found_id) begin
                    // existing id: overwrite its place only
                    n_hit    = 1'b1;
                    n_hslot  = w_sel_id;
                    n_hid    = r_id;
                    n_hplace = r_place;
                    w_wr_en  = 1'b1;
                    w_wr_idx = w_sel_id;
                end else if (r_count < COUNT_BITS'(CAPACITY)) begin
                    // append at the tail
                    n_hslot    = r_count[SLOT_BITS-1:0];
                    n_hid      = r_id;
                    n_hplace   = r_place;
                    n_count    = r_count + COUNT_BITS'(1);
                    w_wr_en    = 1'b1;
                    w_wr_id_en = 1'b1;
                    w_wr_idx   = r_count[SLOT_BITS-1:0];
                end else begin
                    n_ovf = 1'b1;
                end
            end
            OP_FIND_ID, OP_FIND_PLACE: begin
                if ((r_op == OP_FIND_ID) ? w_found_id : w_found_pl) begin
                    n_hit    = 1'b1;
                    n_hslot  = w_sel;
                    n_hid    = r_ids[w_sel];
                    n_hplace = r_places[w_sel];
                end
            end
            OP_ERASE: begin
                if (w_erase_ok) begin
                    // move the tail entry into the hole
                    n_hit      = 1'b1;
                    n_hslot    = r_slot;
                    n_hid      = r_ids[r_slot];
                    n_hplace   = r_places[r_slot];
                    n_count    = r_count - COUNT_BITS'(1);
                    w_wr_en    = 1'b1;
                    w_wr_id_en = 1'b1;
                    w_wr_idx   = r_slot;
                    w_wr_id    = r_ids[w_last];
                    w_wr_place = r_places[w_last];
                end
            end
            default: n_ovf = 1'b0;
        endcase
    end

    // Table write
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr_en) begin
            r_places[w_wr_idx] <= w_wr_place;
            if (w_wr_id_en) begin
                r_ids[w_wr_idx] <= w_wr_id;
            end
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_hit    <= n_hit;
            r_hslot  <= n_hslot;
            r_hid    <= n_hid;
            r_hplace <= n_hplace;
            r_ovf    <= n_ovf;
        end
    end

    assign w_hid_ext    = ID_EXT_W'(r_hid);
    assign w_hplace_ext = PL_EXT_W'(r_hplace);

    assign o_hit       = r_hit;
    assign o_hit_slot  = r_hslot;
    assign o_hit_id    = w_hid_ext[KEY_W-1:0];
    assign o_hit_place = w_hplace_ext[PLACE_W-1:0];
    assign o_occupancy = r_count;
    assign o_overflow  = r_ovf;

endmodule

`default_nettype wire

// ===== rtl/core/binding_table_engine.sv =====
// Flow: an accepted request is captured, then evaluated and its result registered
//   in S_EXEC; evaluation waits while the previous result is still unread.
// Requests: a new one is taken only after the last is evaluated, through capture,
//   whole-table compare, priority select and write-back; one is taken while a result waits.
// Reset: synchronous active-low i_rst_n empties the table (count to zero);
//   entry storage is left as is.
`default_nettype none

module binding_table_engine #(
    parameter int ID_BITS    = 16,
    parameter int PLACE_BITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [bte_pkg::KEY_W-1:0]         i_key_id,
    input  wire logic [bte_pkg::PLACE_W-1:0]       i_place_index,
    input  wire logic [bte_pkg::SLOT_BITS-1:0]     i_slot_index,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_hit,
    output logic [bte_pkg::SLOT_BITS-1:0]          o_hit_slot,
    output logic [bte_pkg::KEY_W-1:0]              o_hit_id,
    output logic [bte_pkg::PLACE_W-1:0]            o_hit_place,
    output logic [bte_pkg::COUNT_BITS-1:0]         o_occupancy,
    output logic                                   o_overflow
);
    import bte_pkg::*;

`include "binding_table_engine_assert.svh"

    t_cmd w_cmd;

    bte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    bte_dpath #(
        .ID_BITS    (ID_BITS),
        .PLACE_BITS (PLACE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_opcode      (i_opcode),
        .i_key_id      (i_key_id),
        .i_place_index (i_place_index),
        .i_slot_index  (i_slot_index),
        .o_hit         (o_hit),
        .o_hit_slot    (o_hit_slot),
        .o_hit_id      (o_hit_id),
        .o_hit_place   (o_hit_place),
        .o_occupancy   (o_occupancy),
        .o_overflow    (o_overflow)
    );

    // One request in flight: accept is always followed by an evaluate cycle
    `BTE_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready, "second request taken during evaluation")
    // Table never reports more entries than it holds
    `BTE_ASSERT_NOW(a_occ_bound, o_out_valid, o_occupancy <= COUNT_BITS'(CAPACITY), "occupancy beyond capacity")
    // A dropped upsert only happens on a full table and never reports a hit
    `BTE_ASSERT_NOW(a_ovf_full, o_out_valid && o_overflow, (o_occupancy == COUNT_BITS'(CAPACITY)) && !o_hit, "overflow without full table")
    // Evaluation only while the output register can take the result
    `BTE_ASSERT_NOW(a_exec_room, w_cmd.exec, !o_out_valid || i_out_ready, "result overwritten before taken")

endmodule

`default_nettype wire
